### rtl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Constants, register indexes and op codes shared by the glyph pixel renderer.
// ----------------------------------------------------------------------------
package gpr_pkg;

    localparam int MATRIX_COLUMNS = 32;
    localparam int MATRIX_ROWS    = 32;
    localparam int GLYPH_WIDTH    = 8;
    localparam int GLYPH_HEIGHT   = 8;
    localparam int GLYPH_COUNT    = 96;

    localparam int FIRST_CODE     = 32;
    localparam int FONT_DEPTH     = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int FONT_AW        = $clog2(FONT_DEPTH);
    localparam int GAMMA_DEPTH    = 256;

    localparam int IN_W           = 40;
    localparam int OUT_W          = 40;

    localparam int REG_COUNT      = 6;
    localparam logic [2:0] REG_FORE_RED   = 3'd0;
    localparam logic [2:0] REG_FORE_GREEN = 3'd1;
    localparam logic [2:0] REG_FORE_BLUE  = 3'd2;
    localparam logic [2:0] REG_BACK_RED   = 3'd3;
    localparam logic [2:0] REG_BACK_GREEN = 3'd4;
    localparam logic [2:0] REG_BACK_BLUE  = 3'd5;

    localparam logic [7:0] FORE_RESET = 8'd255;
    localparam logic [7:0] BACK_RESET = 8'd0;

    localparam logic [1:0] OP_LOAD_FONT  = 2'd0;
    localparam logic [1:0] OP_LOAD_GAMMA = 2'd1;
    localparam logic [1:0] OP_DRAW       = 2'd2;

endpackage

### rtl/glyph_pixel_renderer.sv
// ----------------------------------------------------------------------------
// glyph_pixel_renderer
// Bitmap font character generator producing RGB frame-buffer writes.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one beat per command, op on tuser. Op load-font writes
// one glyph row, op load-gamma writes one gamma entry; both give no output.
// Op draw expands one character into pixel writes on m_axis, one beat per
// on-matrix pixel, tlast on the final one; a draw with nothing on the matrix
// gives no beat. A draw first looks up the six color levels in the gamma
// table through its single port, then per glyph row does one font read and
// sweeps the columns; a row that runs off the bottom ends the draw.
// s_axis_tready is low while a draw runs; loads may follow each other every
// cycle. The output register lets the last pixel wait while the next command
// is taken. When the output register is full and m_axis_tready is low the
// sweep holds on the next visible pixel; off-matrix pixels are skipped at one
// per cycle regardless. Reset sets the color levels to 255 foreground, 0
// background; font and gamma contents are undefined until loaded. Colors
// must change only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module glyph_pixel_renderer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // index[7:0], glyph_row[10:8], load_value[18:11], pos_x[28:19],
    // pos_y[36:29], zero pad[39:37]
    input  logic [gpr_pkg::IN_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // byte_offset[11:0], red[19:12], green[27:20], blue[35:28], zero pad[39:36]
    output logic [gpr_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [7:0]                i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GAM  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_PIX  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [7:0]  r_cfg [gpr_pkg::REG_COUNT];
    logic [7:0]  r_gam [gpr_pkg::REG_COUNT];
    logic [7:0]  font_mem  [gpr_pkg::FONT_DEPTH];
    logic [7:0]  gamma_mem [gpr_pkg::GAMMA_DEPTH];
    logic [7:0]  r_font_q;
    logic [7:0]  r_gamma_q;

    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_i, n_i;
    logic [2:0]  r_j, n_j;
    logic signed [9:0] r_px;
    logic [7:0]  r_py;
    logic [gpr_pkg::FONT_AW-1:0] r_fbase;

    logic                     r_out_valid;
    logic [11:0]              r_out_off;
    logic [7:0]               r_out_r, r_out_g, r_out_b;
    logic                     r_out_last;

    // input fields
    logic [1:0]  w_op;
    logic [7:0]  w_index;
    logic [2:0]  w_grow;
    logic [7:0]  w_lval;
    logic [9:0]  w_posx;
    logic [7:0]  w_posy;
    logic        w_accept;
    logic [7:0]  w_code_off;
    logic        w_code_ok;
    logic [15:0] w_fbase_full;
    logic [15:0] w_faddr_full;

    // sweep
    logic [8:0]  w_row;
    logic        w_row_ok;
    logic signed [10:0] w_col;
    logic        w_col_ok;
    logic        w_out_free;
    logic        w_emit;
    logic        w_step;
    logic        w_lit;
    logic        w_last;
    logic [15:0] w_lin;
    logic [17:0] w_off3;

    assign w_op    = s_axis_tuser;
    assign w_index = s_axis_tdata[7:0];
    assign w_grow  = s_axis_tdata[10:8];
    assign w_lval  = s_axis_tdata[18:11];
    assign w_posx  = s_axis_tdata[28:19];
    assign w_posy  = s_axis_tdata[36:29];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_code_off   = w_index - 8'(gpr_pkg::FIRST_CODE);
    assign w_code_ok    = (w_index >= 8'(gpr_pkg::FIRST_CODE))
                          && (16'(w_code_off) < 16'(gpr_pkg::GLYPH_COUNT));
    assign w_fbase_full = 16'(w_code_off) * 16'(gpr_pkg::GLYPH_HEIGHT);
    assign w_faddr_full = w_fbase_full + 16'(w_grow);

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept && w_op == gpr_pkg::OP_LOAD_FONT && w_code_ok
            && 16'(w_grow) < 16'(gpr_pkg::GLYPH_HEIGHT)
            && w_faddr_full < 16'(gpr_pkg::FONT_DEPTH)) begin
            font_mem[w_faddr_full[gpr_pkg::FONT_AW-1:0]] <= w_lval;
        end
        if (r_state == S_RD) begin
            r_font_q <= font_mem[r_fbase + gpr_pkg::FONT_AW'(r_i)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_op == gpr_pkg::OP_LOAD_GAMMA) begin
            gamma_mem[w_index] <= w_lval;
        end
        if (r_state == S_GAM && 32'(r_cnt) < gpr_pkg::REG_COUNT) begin
            r_gamma_q <= gamma_mem[r_cfg[r_cnt]];
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[gpr_pkg::REG_FORE_RED]   <= gpr_pkg::FORE_RESET;
            r_cfg[gpr_pkg::REG_FORE_GREEN] <= gpr_pkg::FORE_RESET;
            r_cfg[gpr_pkg::REG_FORE_BLUE]  <= gpr_pkg::FORE_RESET;
            r_cfg[gpr_pkg::REG_BACK_RED]   <= gpr_pkg::BACK_RESET;
            r_cfg[gpr_pkg::REG_BACK_GREEN] <= gpr_pkg::BACK_RESET;
            r_cfg[gpr_pkg::REG_BACK_BLUE]  <= gpr_pkg::BACK_RESET;
        end else if (i_cfg_we && 32'(i_cfg_index) < gpr_pkg::REG_COUNT) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // ---------------- pixel sweep ----------------
    assign w_row      = 9'(r_py) + 9'(r_i);
    assign w_row_ok   = w_row < 9'(gpr_pkg::MATRIX_ROWS);
    assign w_col      = 11'(r_px) + 11'(gpr_pkg::GLYPH_WIDTH - 1) - 11'(r_j);
    assign w_col_ok   = (w_col >= 11'sd0) && (w_col < 11'(gpr_pkg::MATRIX_COLUMNS));
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_emit     = (r_state == S_PIX) && w_col_ok && w_out_free;
    assign w_step     = (r_state == S_PIX) && (!w_col_ok || w_out_free);
    assign w_lit      = r_font_q[r_j];
    // valid columns and rows are contiguous, so the final pixel is found locally
    assign w_last     = (r_j == 3'(gpr_pkg::GLYPH_WIDTH - 1) || w_col == 11'sd0)
                        && (r_i == 3'(gpr_pkg::GLYPH_HEIGHT - 1)
                            || w_row == 9'(gpr_pkg::MATRIX_ROWS - 1));
    assign w_lin      = 16'(w_col[9:0]) + 16'(w_row) * 16'(gpr_pkg::MATRIX_COLUMNS);
    assign w_off3     = 18'(w_lin) * 18'd3;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_op == gpr_pkg::OP_DRAW && w_code_ok) begin
                    n_state = S_GAM;
                    n_cnt   = 3'd0;
                    n_i     = 3'd0;
                end
            end
            S_GAM: begin
                if (32'(r_cnt) == gpr_pkg::REG_COUNT) begin
                    n_state = S_RD;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_RD: begin
                n_j = 3'd0;
                if (w_row_ok) begin
                    n_state = S_PIX;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PIX: begin
                if (w_step) begin
                    if (r_j == 3'(gpr_pkg::GLYPH_WIDTH - 1)) begin
                        if (r_i == 3'(gpr_pkg::GLYPH_HEIGHT - 1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_i     = r_i + 3'd1;
                            n_state = S_RD;
                        end
                    end else begin
                        n_j = r_j + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_i   <= n_i;
        r_j   <= n_j;
        if (w_accept) begin
            r_px    <= w_posx;
            r_py    <= w_posy;
            r_fbase <= w_fbase_full[gpr_pkg::FONT_AW-1:0];
        end
        if (r_state == S_GAM && r_cnt != 3'd0) begin
            r_gam[r_cnt - 3'd1] <= r_gamma_q;
        end
        if (w_emit) begin
            r_out_off  <= w_off3[11:0];
            r_out_r    <= w_lit ? r_gam[gpr_pkg::REG_FORE_RED]   : r_gam[gpr_pkg::REG_BACK_RED];
            r_out_g    <= w_lit ? r_gam[gpr_pkg::REG_FORE_GREEN] : r_gam[gpr_pkg::REG_BACK_GREEN];
            r_out_b    <= w_lit ? r_gam[gpr_pkg::REG_FORE_BLUE]  : r_gam[gpr_pkg::REG_BACK_BLUE];
            r_out_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_b, r_out_g, r_out_r, r_out_off};
    assign m_axis_tlast  = r_out_last;

endmodule

### tb/glyph_pixel_renderer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_pixel_renderer_tb
// Self-checking bench for the glyph pixel renderer. Commands go in on the
// input stream; every pixel beat is compared with a local predictor that
// keeps its own font store, gamma table and color levels. A directed table
// covers field extremes and the skip cases, then random phases upload glyphs,
// reprogram colors and draw at random positions, with random ready/valid gaps.
// ----------------------------------------------------------------------------
module glyph_pixel_renderer_tb;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int TOTAL_CMDS   = 430;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] code;
        logic [2:0] grow;
        logic [7:0] value;
        logic [9:0] px;
        logic [7:0] py;
    } t_cmd;

    typedef struct packed {
        t_cmd c;
        bit   blank;   // no pixel beat may come from this command
    } t_dir_row;

    typedef struct packed {
        logic [11:0] offset;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } t_pixel;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [gpr_pkg::IN_W-1:0] s_axis_tdata;
    logic [1:0]               s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [gpr_pkg::OUT_W-1:0] m_axis_tdata;
    logic                     m_axis_tlast;
    logic                     i_cfg_we;
    logic [2:0]               i_cfg_index;
    logic [7:0]               i_cfg_data;

    glyph_pixel_renderer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0] font_mem  [gpr_pkg::FONT_DEPTH];
    logic [7:0] gamma_mem [gpr_pkg::GAMMA_DEPTH];
    logic [7:0] color_lvl [gpr_pkg::REG_COUNT];
    logic [7:0] rows_loaded [256];
    logic [7:0] ready_codes [$];
    t_pixel     pending_pixels [$];

    int  mismatches  = 0;
    int  pixels_seen = 0;
    int  cmds_sent   = 0;
    bit  tail_mode   = 1'b0;

    t_dir_row directed_rows [0:24] = '{
        '{'{gpr_pkg::OP_LOAD_GAMMA, 8'd0,   3'd0, 8'h01, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_GAMMA, 8'd255, 3'd0, 8'hFE, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd32,  3'd0, 8'h81, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd32,  3'd1, 8'hFF, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd32,  3'd2, 8'h00, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd32,  3'd3, 8'h01, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd32,  3'd4, 8'h80, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd32,  3'd5, 8'h55, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd32,  3'd6, 8'hAA, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd32,  3'd7, 8'h3C, 10'h000, 8'd0},   1'b1},
        // codes outside the font: ignored
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd31,  3'd0, 8'hFF, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_LOAD_FONT,  8'd128, 3'd7, 8'hFF, 10'h000, 8'd0},   1'b1},
        '{'{OP_SPARE,               8'd255, 3'd7, 8'hFF, 10'h3FF, 8'd255}, 1'b1},
        '{'{gpr_pkg::OP_DRAW,       8'd32,  3'd0, 8'h00, 10'h000, 8'd0},   1'b0},
        '{'{gpr_pkg::OP_DRAW,       8'd32,  3'd0, 8'h00, 10'h018, 8'd24},  1'b0},
        '{'{gpr_pkg::OP_DRAW,       8'd32,  3'd0, 8'h00, 10'h3FC, 8'd28},  1'b0},
        '{'{gpr_pkg::OP_DRAW,       8'd32,  3'd0, 8'h00, 10'h01F, 8'd31},  1'b0},
        // cells wholly off the matrix, then codes outside the font
        '{'{gpr_pkg::OP_DRAW,       8'd32,  3'd7, 8'hFF, 10'h200, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_DRAW,       8'd32,  3'd0, 8'h00, 10'h1FF, 8'd255}, 1'b1},
        '{'{gpr_pkg::OP_DRAW,       8'd32,  3'd0, 8'h00, 10'h020, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_DRAW,       8'd32,  3'd0, 8'h00, 10'h3F8, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_DRAW,       8'd32,  3'd0, 8'h00, 10'h000, 8'd32},  1'b1},
        '{'{gpr_pkg::OP_DRAW,       8'd31,  3'd0, 8'h00, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_DRAW,       8'd128, 3'd0, 8'h00, 10'h000, 8'd0},   1'b1},
        '{'{gpr_pkg::OP_DRAW,       8'd255, 3'd0, 8'h00, 10'h3F9, 8'd31},  1'b1}
    };

    function automatic bit code_in_font(input logic [7:0] code);
        return code >= gpr_pkg::FIRST_CODE
               && code < gpr_pkg::FIRST_CODE + gpr_pkg::GLYPH_COUNT;
    endfunction

    // Update the predictor with one accepted command; queue its pixels if keep.
    task automatic apply_cmd(input t_cmd c, input bit keep);
        int     sx;
        int     row;
        int     col;
        int     addr;
        logic   lit;
        logic [7:0] bits;
        t_pixel p;
        t_pixel held;
        bit     have_held;
        have_held = 1'b0;
        case (c.op)
            gpr_pkg::OP_LOAD_FONT: begin
                if (code_in_font(c.code) && c.grow < gpr_pkg::GLYPH_HEIGHT) begin
                    addr = (int'(c.code) - gpr_pkg::FIRST_CODE) * gpr_pkg::GLYPH_HEIGHT
                           + int'(c.grow);
                    font_mem[addr] = c.value;
                    if (rows_loaded[c.code] != 8'hFF) begin
                        rows_loaded[c.code][c.grow] = 1'b1;
                        if (rows_loaded[c.code] == 8'hFF)
                            ready_codes.push_back(c.code);
                    end
                end
            end
            gpr_pkg::OP_LOAD_GAMMA: begin
                gamma_mem[c.code] = c.value;
            end
            gpr_pkg::OP_DRAW: begin
                if (code_in_font(c.code)) begin
                    sx = int'(c.px);
                    if (sx >= 512)
                        sx = sx - 1024;
                    for (int i = 0; i < gpr_pkg::GLYPH_HEIGHT; i++) begin
                        row = int'(c.py) + i;
                        if (row < gpr_pkg::MATRIX_ROWS) begin
                            addr = (int'(c.code) - gpr_pkg::FIRST_CODE)
                                   * gpr_pkg::GLYPH_HEIGHT + i;
                            bits = font_mem[addr];
                            for (int j = 0; j < gpr_pkg::GLYPH_WIDTH; j++) begin
                                col = sx + gpr_pkg::GLYPH_WIDTH - 1 - j;
                                if (col >= 0 && col < gpr_pkg::MATRIX_COLUMNS) begin
                                    lit = bits[j];
                                    p.offset = 12'((col + row * gpr_pkg::MATRIX_COLUMNS) * 3);
                                    if (lit) begin
                                        p.red   = gamma_mem[color_lvl[gpr_pkg::REG_FORE_RED]];
                                        p.green = gamma_mem[color_lvl[gpr_pkg::REG_FORE_GREEN]];
                                        p.blue  = gamma_mem[color_lvl[gpr_pkg::REG_FORE_BLUE]];
                                    end else begin
                                        p.red   = gamma_mem[color_lvl[gpr_pkg::REG_BACK_RED]];
                                        p.green = gamma_mem[color_lvl[gpr_pkg::REG_BACK_GREEN]];
                                        p.blue  = gamma_mem[color_lvl[gpr_pkg::REG_BACK_BLUE]];
                                    end
                                    p.last   = 1'b0;
                                    if (have_held && keep)
                                        pending_pixels.push_back(held);
                                    held = p;
                                    have_held = 1'b1;
                                end
                            end
                        end
                    end
                    if (have_held && keep) begin
                        held.last = 1'b1;
                        pending_pixels.push_back(held);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // One beat on the input stream; called and returns at a falling edge.
    task automatic send_cmd(input t_cmd c, input bit keep);
        if (!tail_mode && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, c.py, c.px, c.value, c.grow, c.code};
        s_axis_tuser  <= c.op;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1)
            @(posedge i_clk);
        apply_cmd(c, keep);
        cmds_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_cmd random_cmd(input logic [1:0] op);
        t_cmd c;
        c.op    = op;
        c.code  = 8'($urandom_range(0, 255));
        c.grow  = 3'($urandom_range(0, 7));
        c.value = 8'($urandom_range(0, 255));
        c.px    = 10'($urandom_range(0, 1023));
        c.py    = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] random_row_bits();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic upload_glyph(input logic [7:0] code, input int first, input int count);
        t_cmd c;
        for (int r = first; r < first + count; r++) begin
            c = random_cmd(gpr_pkg::OP_LOAD_FONT);
            c.code  = code;
            c.grow  = 3'(r);
            c.value = random_row_bits();
            send_cmd(c, 1'b1);
        end
    endtask

    task automatic draw_random();
        t_cmd c;
        c = random_cmd(gpr_pkg::OP_DRAW);
        c.code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
        if ($urandom_range(0, 4) != 0) begin
            c.px = 10'($urandom_range(0, 41) - 9);
            c.py = 8'($urandom_range(0, 33));
        end
        send_cmd(c, 1'b1);
    endtask

    task automatic random_noise();
        t_cmd c;
        case ($urandom_range(0, 3))
            0: begin
                c = random_cmd(gpr_pkg::OP_LOAD_FONT);
                c.code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                              : 8'($urandom_range(128, 255));
                send_cmd(c, 1'b1);
            end
            1: send_cmd(random_cmd(OP_SPARE), 1'b1);
            2: begin
                c = random_cmd(gpr_pkg::OP_DRAW);
                c.code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                              : 8'($urandom_range(128, 255));
                send_cmd(c, 1'b1);
            end
            default: upload_glyph(8'($urandom_range(32, 127)), 0, $urandom_range(1, 7));
        endcase
    endtask

    task automatic set_color(input logic [2:0] idx, input logic [7:0] lvl);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= lvl;
        @(negedge i_clk);
        color_lvl[idx] = lvl;
    endtask

    // Colors change only while idle; the gamma entries they use are loaded after.
    task automatic program_colors(input logic [7:0] lvl [gpr_pkg::REG_COUNT]);
        t_cmd c;
        set_color(gpr_pkg::REG_FORE_RED,   lvl[gpr_pkg::REG_FORE_RED]);
        set_color(gpr_pkg::REG_FORE_GREEN, lvl[gpr_pkg::REG_FORE_GREEN]);
        set_color(gpr_pkg::REG_FORE_BLUE,  lvl[gpr_pkg::REG_FORE_BLUE]);
        set_color(gpr_pkg::REG_BACK_RED,   lvl[gpr_pkg::REG_BACK_RED]);
        set_color(gpr_pkg::REG_BACK_GREEN, lvl[gpr_pkg::REG_BACK_GREEN]);
        set_color(gpr_pkg::REG_BACK_BLUE,  lvl[gpr_pkg::REG_BACK_BLUE]);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < gpr_pkg::REG_COUNT; k++) begin
            c = random_cmd(gpr_pkg::OP_LOAD_GAMMA);
            c.code = lvl[k];
            send_cmd(c, 1'b1);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] lvl [gpr_pkg::REG_COUNT];
        int         phase_end;
        int         pick;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = gpr_pkg::OP_LOAD_FONT;
        i_cfg_we      = 1'b0;
        i_cfg_index   = gpr_pkg::REG_FORE_RED;
        i_cfg_data    = '0;
        for (int k = 0; k < 256; k++)
            rows_loaded[k] = 8'h00;
        color_lvl[gpr_pkg::REG_FORE_RED]   = gpr_pkg::FORE_RESET;
        color_lvl[gpr_pkg::REG_FORE_GREEN] = gpr_pkg::FORE_RESET;
        color_lvl[gpr_pkg::REG_FORE_BLUE]  = gpr_pkg::FORE_RESET;
        color_lvl[gpr_pkg::REG_BACK_RED]   = gpr_pkg::BACK_RESET;
        color_lvl[gpr_pkg::REG_BACK_GREEN] = gpr_pkg::BACK_RESET;
        color_lvl[gpr_pkg::REG_BACK_BLUE]  = gpr_pkg::BACK_RESET;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k])
            send_cmd(directed_rows[k].c, !directed_rows[k].blank);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            for (int k = 0; k < gpr_pkg::REG_COUNT; k++) begin
                if (p == 0)
                    lvl[k] = (k < 3) ? 8'h00 : 8'hFF;
                else
                    lvl[k] = 8'($urandom_range(0, 255));
            end
            program_colors(lvl);
            if (p == PHASES - 1)
                tail_mode = 1'b1;
            if (p == 0)
                upload_glyph(8'd127, 0, gpr_pkg::GLYPH_HEIGHT);
            phase_end = 25 + (p + 1) * (TOTAL_CMDS - 25) / PHASES;
            while (cmds_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    upload_glyph(8'($urandom_range(32, 127)), 0, gpr_pkg::GLYPH_HEIGHT);
                else if (pick < 20)
                    send_cmd(random_cmd(gpr_pkg::OP_LOAD_GAMMA), 1'b1);
                else if (pick < 25)
                    random_noise();
                else
                    draw_random();
            end
        end

        settle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // output side ready: random stalls, one long hold, none in the tail
    initial begin : sink_ready
        bit long_hold_done;
        long_hold_done = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && pixels_seen >= 300) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (!tail_mode && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : pixel_check
        t_pixel want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                $display("%0t ns: pixel beat expected none got offset %0d",
                         $time, m_axis_tdata[11:0]);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("offset", want.offset, m_axis_tdata[11:0]);
                check_field("red",    want.red,    m_axis_tdata[19:12]);
                check_field("green",  want.green,  m_axis_tdata[27:20]);
                check_field("blue",   want.blue,   m_axis_tdata[35:28]);
                check_field("last",   want.last,   m_axis_tlast);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
